FILE: hw/rtl/cia_pkg.sv
// ----------------------------------------------------------------------------
// Complex integer ALU package
// Command codes and size constants shared by the ALU modules.
// ----------------------------------------------------------------------------
package cia_pkg;

  localparam int unsigned OPW_DEFAULT = 16;   // operand width used inside
  localparam int unsigned IN_W        = 16;   // width of an operand field
  localparam int unsigned RES_W       = 33;   // width of a result part
  localparam int unsigned EXT_W       = 64;   // exact intermediate width
  localparam int unsigned FIFO_DEPTH  = 4;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_NEG = 3'd4,
    CMD_EQ  = 3'd5,
    CMD_NE  = 3'd6
  } cmd_t;

endpackage

FILE: hw/rtl/cia_if.sv
// ----------------------------------------------------------------------------
// Complex integer ALU channels
// Valid/ready interfaces for operand items and result items.
// ----------------------------------------------------------------------------
interface cia_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [15:0] a_re;
  logic [15:0] a_im;
  logic [15:0] b_re;
  logic [15:0] b_im;

  modport source (output valid, command, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, command, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cia_out_if;
  logic        valid;
  logic        ready;
  logic [32:0] result_re;
  logic [32:0] result_im;
  logic        is_true;
  logic        div_zero;

  modport source (output valid, result_re, result_im, is_true, div_zero, input ready);
  modport sink   (input valid, result_re, result_im, is_true, div_zero, output ready);
endinterface

FILE: hw/rtl/complex_integer_alu_top.sv
// ----------------------------------------------------------------------------
// Complex integer ALU
// Add, subtract, multiply, divide, negate and compare of complex integers.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  in_ch    in   valid/ready        command, a_re, a_im, b_re, b_im
//  out_ch   out  valid/ready        result_re, result_im, is_true, div_zero
//
//  One item per cycle sustained while out_ch is not stalled; every command
//  takes the same path. An item passes the front register, the queue, the
//  sum stage and one divider stage per quotient bit, then the result sits
//  in the output register.
//  Synchronous active-low reset empties all stages; no clearing pass.
//  A stalled output holds the back end; the queue then absorbs the front.
module complex_integer_alu_top import cia_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OPW_DEFAULT
) (
  input  logic      clk,
  input  logic      rst_n,
  cia_in_if.sink    in_ch,
  cia_out_if.source out_ch
);

  localparam int unsigned DW = 5 + 2 * (2 * OPERAND_WIDTH + 1) + 12 * OPERAND_WIDTH;

  logic          push, full, pop, empty;
  logic [DW-1:0] push_data, pop_data;

  cia_front #(.OPW(OPERAND_WIDTH), .DW(DW)) u_front (
    .clk, .rst_n, .in_ch, .push, .full, .push_data
  );

  cia_fifo #(.DW(DW), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk, .rst_n, .push, .push_data, .full, .pop, .empty, .pop_data
  );

  cia_back #(.OPW(OPERAND_WIDTH), .DW(DW)) u_back (
    .clk, .rst_n, .empty, .pop_data, .pop, .out_ch
  );

endmodule

FILE: hw/rtl/cia_front.sv
// ----------------------------------------------------------------------------
// Complex integer ALU front end
// Accepts items, sign-extends operands, decodes the command and forms the
// products, simple results and flags in one registered stage.
// ----------------------------------------------------------------------------
module cia_front import cia_pkg::*; #(
  parameter int unsigned OPW = OPW_DEFAULT,
  parameter int unsigned DW  = 5 + 2 * (2 * OPW + 1) + 12 * OPW
) (
  input  logic          clk,
  input  logic          rst_n,
  cia_in_if.sink        in_ch,
  output logic          push,
  input  logic          full,
  output logic [DW-1:0] push_data
);

  localparam int unsigned PW = 2 * OPW;
  localparam int unsigned SW = 2 * OPW + 1;

  logic signed [OPW-1:0] ar, ai, br, bi;
  logic signed [PW-1:0]  xar, xai, xbr, xbi;
  logic signed [SW-1:0]  sre, sim;
  logic                  tru, dz;
  cmd_t                  cmd;

  logic                  vld_r;
  logic [DW-1:0]         data_r, data_nxt;

  function automatic logic signed [OPW-1:0] take_op(input logic [IN_W-1:0] v);
    logic [EXT_W-1:0] z;
    z = EXT_W'(v);
    return z[OPW-1:0];
  endfunction

  always_comb begin
    cmd = cmd_t'(in_ch.command);
    ar  = take_op(in_ch.a_re);
    ai  = take_op(in_ch.a_im);
    br  = take_op(in_ch.b_re);
    bi  = take_op(in_ch.b_im);
    xar = PW'(ar);
    xai = PW'(ai);
    xbr = PW'(br);
    xbi = PW'(bi);
    sre = '0;
    sim = '0;
    tru = 1'b0;
    dz  = 1'b0;
    case (cmd)
      CMD_ADD: begin
        sre = SW'(ar) + SW'(br);
        sim = SW'(ai) + SW'(bi);
      end
      CMD_SUB: begin
        sre = SW'(ar) - SW'(br);
        sim = SW'(ai) - SW'(bi);
      end
      CMD_NEG: begin
        sre = -SW'(ar);
        sim = -SW'(ai);
      end
      CMD_DIV: dz  = (br == '0) && (bi == '0);
      CMD_EQ:  tru = (ar == br) && (ai == bi);
      CMD_NE:  tru = (ar != br) || (ai != bi);
      default: ;
    endcase
    data_nxt = {in_ch.command, tru, dz, sre, sim,
                xar * xbr, xai * xbi, xai * xbr, xar * xbi,
                xbr * xbr, xbi * xbi};
  end

  assign push        = vld_r && !full;
  assign push_data   = data_r;
  // hold off items while reset is asserted
  assign in_ch.ready = rst_n && (!vld_r || !full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

FILE: hw/rtl/cia_fifo.sv
// ----------------------------------------------------------------------------
// Complex integer ALU queue
// Small show-ahead queue between the front end and the back end.
// ----------------------------------------------------------------------------
module cia_fifo import cia_pkg::*; #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = FIFO_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output logic [DW-1:0] pop_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = (cnt_r == (AW + 1)'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem[rd_r];

  always_comb begin
    wr_nxt  = push ? bump(wr_r) : wr_r;
    rd_nxt  = pop  ? bump(rd_r) : rd_r;
    cnt_nxt = cnt_r + (AW + 1)'(push) - (AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/cia_back.sv
// ----------------------------------------------------------------------------
// Complex integer ALU back end
// Forms the product sums, runs both quotients through a restoring divider
// pipeline of one bit per stage, fixes signs and registers the result.
// ----------------------------------------------------------------------------
module cia_back import cia_pkg::*; #(
  parameter int unsigned OPW = OPW_DEFAULT,
  parameter int unsigned DW  = 5 + 2 * (2 * OPW + 1) + 12 * OPW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          empty,
  input  logic [DW-1:0] pop_data,
  output logic          pop,
  cia_out_if.source     out_ch
);

  localparam int unsigned PW = 2 * OPW;
  localparam int unsigned SW = 2 * OPW + 1;
  localparam int unsigned NS = PW;   // one quotient bit per stage

  logic [2:0]           f_cmd;
  logic                 f_tru, f_dz;
  logic signed [SW-1:0] f_sre, f_sim;
  logic signed [PW-1:0] p_rr, p_ii, p_ir, p_ri, m_rr, m_ii;
  logic signed [SW-1:0] n_re, n_im, s_re, s_im;
  logic                 adv;

  // stage arrays: index 0 is the sum stage, index NS the last divider step
  logic                 vld_r  [NS+1];
  logic                 div_r  [NS+1];
  logic                 tru_r  [NS+1];
  logic                 dz_r   [NS+1];
  logic signed [SW-1:0] rre_r  [NS+1];
  logic signed [SW-1:0] rim_r  [NS+1];
  logic                 ngr_r  [NS+1];
  logic                 ngi_r  [NS+1];
  logic [PW-1:0]        qre_r  [NS+1];
  logic [PW-1:0]        qim_r  [NS+1];
  logic [PW-1:0]        rmr_r  [NS+1];
  logic [PW-1:0]        rmi_r  [NS+1];
  logic [PW-1:0]        d_r    [NS+1];

  logic                 ov_r;
  logic [RES_W-1:0]     ore_r, oim_r, ore_nxt, oim_nxt;
  logic                 otr_r, odz_r;

  typedef struct packed {
    logic [PW-1:0] q;
    logic [PW-1:0] rem;
  } dstep_t;

  function automatic dstep_t div_step(input logic [PW-1:0] q, input logic [PW-1:0] rem,
                                      input logic [PW-1:0] d);
    logic [PW:0] sh;
    dstep_t      o;
    sh    = {rem, q[PW-1]};
    o.q   = {q[PW-2:0], 1'b0};
    o.rem = sh[PW-1:0];
    if (sh >= {1'b0, d}) begin
      o.rem  = PW'(sh - {1'b0, d});
      o.q[0] = 1'b1;
    end
    return o;
  endfunction

  function automatic logic [PW-1:0] mag(input logic signed [SW-1:0] v);
    logic [SW-1:0] u;
    u = v[SW-1] ? SW'(-v) : SW'(v);
    return u[PW-1:0];
  endfunction

  function automatic logic [RES_W-1:0] wrap(input logic signed [SW-1:0] v);
    logic signed [EXT_W-1:0] x;
    x = EXT_W'(v);
    return x[RES_W-1:0];
  endfunction

  function automatic logic [RES_W-1:0] signq(input logic [PW-1:0] q, input logic ng);
    logic [EXT_W-1:0] x;
    x = EXT_W'(q);
    if (ng) x = -x;
    return x[RES_W-1:0];
  endfunction

  assign adv = !ov_r || out_ch.ready;
  assign pop = adv && !empty;

  always_comb begin
    {f_cmd, f_tru, f_dz, f_sre, f_sim, p_rr, p_ii, p_ir, p_ri, m_rr, m_ii} = pop_data;
    n_re = SW'(p_rr) + SW'(p_ii);
    n_im = SW'(p_ir) - SW'(p_ri);
    s_re = f_sre;
    s_im = f_sim;
    if (cmd_t'(f_cmd) == CMD_MUL) begin
      s_re = SW'(p_rr) - SW'(p_ii);
      s_im = SW'(p_ir) + SW'(p_ri);
    end
  end

  always_comb begin
    ore_nxt = wrap(rre_r[NS]);
    oim_nxt = wrap(rim_r[NS]);
    if (div_r[NS]) begin
      ore_nxt = signq(qre_r[NS], ngr_r[NS]);
      oim_nxt = signq(qim_r[NS], ngi_r[NS]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NS; k++) vld_r[k] <= 1'b0;
      ov_r <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= !empty;
      for (int k = 1; k <= NS; k++) vld_r[k] <= vld_r[k-1];
      ov_r <= vld_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    dstep_t sr, si;
    if (adv) begin
      // sum stage
      div_r[0] <= (cmd_t'(f_cmd) == CMD_DIV) && !f_dz;
      tru_r[0] <= f_tru;
      dz_r[0]  <= f_dz;
      rre_r[0] <= s_re;
      rim_r[0] <= s_im;
      ngr_r[0] <= n_re[SW-1];
      ngi_r[0] <= n_im[SW-1];
      qre_r[0] <= mag(n_re);
      qim_r[0] <= mag(n_im);
      rmr_r[0] <= '0;
      rmi_r[0] <= '0;
      d_r[0]   <= PW'(m_rr) + PW'(m_ii);
      // divider steps
      for (int k = 1; k <= NS; k++) begin
        sr = div_step(qre_r[k-1], rmr_r[k-1], d_r[k-1]);
        si = div_step(qim_r[k-1], rmi_r[k-1], d_r[k-1]);
        div_r[k] <= div_r[k-1];
        tru_r[k] <= tru_r[k-1];
        dz_r[k]  <= dz_r[k-1];
        rre_r[k] <= rre_r[k-1];
        rim_r[k] <= rim_r[k-1];
        ngr_r[k] <= ngr_r[k-1];
        ngi_r[k] <= ngi_r[k-1];
        d_r[k]   <= d_r[k-1];
        qre_r[k] <= sr.q;
        rmr_r[k] <= sr.rem;
        qim_r[k] <= si.q;
        rmi_r[k] <= si.rem;
      end
      // output register
      ore_r <= ore_nxt;
      oim_r <= oim_nxt;
      otr_r <= tru_r[NS];
      odz_r <= dz_r[NS];
    end
  end

  assign out_ch.valid     = ov_r;
  assign out_ch.result_re = ore_r;
  assign out_ch.result_im = oim_r;
  assign out_ch.is_true   = otr_r;
  assign out_ch.div_zero  = odz_r;

endmodule

FILE: hw/rtl/cia_checker.sv
// ----------------------------------------------------------------------------
// Complex integer ALU checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module cia_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [32:0] out_re,
  input logic [32:0] out_im,
  input logic        out_true,
  input logic        out_dz
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_re) && $stable(out_im))
    else $error("result item changed while stalled");

  a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_true |-> out_re == '0 && out_im == '0 && !out_dz)
    else $error("comparison item has nonzero parts");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dz |-> out_re == '0 && out_im == '0 && !out_true)
    else $error("divide by zero item has nonzero parts");

endmodule

bind complex_integer_alu_top cia_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_re    (out_ch.result_re),
  .out_im    (out_ch.result_im),
  .out_true  (out_ch.is_true),
  .out_dz    (out_ch.div_zero)
);

FILE: tb/tb_complex_integer_alu_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Complex integer ALU testbench
// Drives operand items through the input channel and compares every result
// against a local complex-arithmetic predictor, idling both channels at random
// but in the final full-rate mix. Directed corners, mixes, divides first.
// ----------------------------------------------------------------------------
module tb_complex_integer_alu_top;
  import cia_pkg::*;

  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int unsigned ALU_LATENCY = 2 * OPW_DEFAULT + 3;

  typedef struct packed {
    logic [32:0] re;
    logic [32:0] im;
    logic        is_true;
    logic        div_zero;
  } alu_result_t;

  logic clk;
  logic rst_n;
  bit   idle_on;
  int   mismatch_cnt;
  int   result_cnt;
  int   op_cnt [8];
  int   div_zero_cnt;

  alu_result_t expected_results [$];

  cia_in_if  in_if ();
  cia_out_if out_if ();

  complex_integer_alu_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("timeout: %0d results still outstanding", expected_results.size());
    $display("** complex_integer_alu_top: FAILED **");
    $finish;
  end

  // Exact complex arithmetic, cut to the result width.
  function automatic alu_result_t predict_alu(logic [2:0] cmd, logic [15:0] a_re_b,
                                              logic [15:0] a_im_b, logic [15:0] b_re_b,
                                              logic [15:0] b_im_b);
    alu_result_t r;
    longint ar, ai, br, bi, re, im, mag;
    ar = longint'($signed(a_re_b));
    ai = longint'($signed(a_im_b));
    br = longint'($signed(b_re_b));
    bi = longint'($signed(b_im_b));
    re = 0;
    im = 0;
    r = '0;
    case (cmd)
      CMD_ADD: begin re = ar + br; im = ai + bi; end
      CMD_SUB: begin re = ar - br; im = ai - bi; end
      CMD_MUL: begin re = ar * br - ai * bi; im = ai * br + ar * bi; end
      CMD_DIV: begin
        mag = br * br + bi * bi;
        if (mag == 0) begin
          r.div_zero = 1'b1;
        end else begin
          re = (ar * br + ai * bi) / mag;
          im = (ai * br - ar * bi) / mag;
        end
      end
      CMD_NEG: begin re = -ar; im = -ai; end
      CMD_EQ:  r.is_true = (ar == br) && (ai == bi);
      CMD_NE:  r.is_true = (ar != br) || (ai != bi);
      default: ;
    endcase
    r.re = re[32:0];
    r.im = im[32:0];
    return r;
  endfunction

  // Send one item; valid stays high until the caller's next step.
  task automatic send_op(logic [2:0] cmd, logic [15:0] ar, logic [15:0] ai,
                         logic [15:0] br, logic [15:0] bi);
    while (idle_on && $urandom_range(99) < 13) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.command <= cmd;
    in_if.a_re    <= ar;
    in_if.a_im    <= ai;
    in_if.b_re    <= br;
    in_if.b_im    <= bi;
    do @(posedge clk); while (!in_if.ready);
    expected_results.push_back(predict_alu(cmd, ar, ai, br, bi));
    op_cnt[cmd]++;
    if (cmd == CMD_DIV && br == 16'd0 && bi == 16'd0) div_zero_cnt++;
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_operand();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(16)) - 8);
      3: return 16'(int'($urandom_range(512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] rand_cmd();
    logic [2:0] c;
    c = 3'($urandom_range(6));
    if ($urandom_range(49) == 0) c = CMD_UNUSED;
    return c;
  endfunction

  task automatic test_directed();
    send_op(CMD_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_op(CMD_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_op(CMD_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_op(CMD_SUB, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_op(CMD_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_op(CMD_MUL, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_op(CMD_MUL, 16'h7fff, 16'h8000, 16'h8000, 16'h8000);
    send_op(CMD_DIV, 16'h1234, 16'hfedc, 16'h0000, 16'h0000);
    send_op(CMD_DIV, 16'h8000, 16'h8000, 16'h0000, 16'h0001);
    send_op(CMD_DIV, 16'h8000, 16'h7fff, 16'h8000, 16'h8000);
    send_op(CMD_DIV, 16'h0007, 16'hfff9, 16'h0002, 16'h0000);
    send_op(CMD_DIV, 16'hfff9, 16'h0007, 16'h0002, 16'h0001);
    send_op(CMD_DIV, 16'h7fff, 16'h7fff, 16'hffff, 16'h0000);
    send_op(CMD_NEG, 16'h8000, 16'h7fff, 16'h0000, 16'h0000);
    send_op(CMD_NEG, 16'h0000, 16'hffff, 16'h5555, 16'haaaa);
    send_op(CMD_EQ,  16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_op(CMD_EQ,  16'h8000, 16'h7fff, 16'h8000, 16'h7ffe);
    send_op(CMD_NE,  16'h1234, 16'h5678, 16'h1234, 16'h5678);
    send_op(CMD_NE,  16'h1234, 16'h5678, 16'h1235, 16'h5678);
    send_op(CMD_UNUSED, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
  endtask

  task automatic test_random_mix(int n);
    logic [2:0]  c;
    logic [15:0] ar, ai, br, bi;
    repeat (n) begin
      c  = rand_cmd();
      ar = rand_operand();
      ai = rand_operand();
      br = rand_operand();
      bi = rand_operand();
      if ((c == CMD_EQ || c == CMD_NE) && $urandom_range(1)) begin
        br = ar;
        bi = ai;
        if ($urandom_range(1)) bi = ai ^ (16'd1 << $urandom_range(15));
      end
      send_op(c, ar, ai, br, bi);
    end
  endtask

  // Divides by small divisors, so quotients are mostly nonzero, or by zero.
  task automatic test_divide(int n);
    logic [15:0] br, bi;
    repeat (n) begin
      br = 16'(int'($urandom_range(64)) - 32);
      bi = 16'(int'($urandom_range(64)) - 32);
      if ($urandom_range(9) == 0) begin br = '0; bi = '0; end
      send_op(CMD_DIV, 16'($urandom), 16'($urandom), br, bi);
    end
  endtask

  task automatic test_full_rate(int n);
    idle_on = 1'b0;
    test_random_mix(n);
    idle_on = 1'b1;
  endtask

  always @(negedge clk) begin
    out_if.ready <= idle_on ? ($urandom_range(99) >= 13) : 1'b1;
  end

  always @(posedge clk) begin
    alu_result_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      result_cnt++;
      if (expected_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        exp_r = expected_results.pop_front();
        if (out_if.result_re !== exp_r.re || out_if.result_im !== exp_r.im ||
            out_if.is_true !== exp_r.is_true || out_if.div_zero !== exp_r.div_zero) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch at %0t: exp re=%h im=%h t=%b dz=%b, got re=%h im=%h t=%b dz=%b",
                     $realtime, exp_r.re, exp_r.im, exp_r.is_true, exp_r.div_zero,
                     out_if.result_re, out_if.result_im, out_if.is_true, out_if.div_zero);
        end
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    idle_on       = 1'b1;
    in_if.valid   = 1'b0;
    in_if.command = CMD_ADD;
    in_if.a_re    = '0;
    in_if.a_im    = '0;
    in_if.b_re    = '0;
    in_if.b_im    = '0;
    out_if.ready  = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random_mix(600);
    test_divide(250);
    test_full_rate(330);
    in_if.valid <= 1'b0;

    wait (expected_results.size() == 0);
    repeat (ALU_LATENCY + 20) @(posedge clk);

    $display("checked %0d results: add %0d sub %0d mul %0d div %0d neg %0d eq %0d ne %0d",
             result_cnt, op_cnt[0], op_cnt[1], op_cnt[2], op_cnt[3], op_cnt[4],
             op_cnt[5], op_cnt[6]);
    $display("unused code %0d, divide by zero %0d, mismatches %0d",
             op_cnt[7], div_zero_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("** complex_integer_alu_top: PASSED **");
    end else begin
      $display("** complex_integer_alu_top: FAILED **");
    end
    $finish;
  end

endmodule
